// ===== sv/ncep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest cover edge pool package
// Shared widths, codes, entry and control types for the pool and its cells.
// ----------------------------------------------------------------------------
package ncep_pkg;

  localparam int POOL_DEPTH_DEF = 128;
  localparam int COORD_W = 29;
  localparam int FLAGS_W = 7;
  localparam int DIST_W = 35;
  localparam int BUCKET_W = 4;
  localparam int READ_IDX_W = 7;
  localparam int COUNT_OUT_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam logic [BUCKET_W-1:0] MIN_COVER_BUCKET = 4'd2;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_OFFER = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_X   = 2'd0,
    REG_QUERY_Y   = 2'd1,
    REG_QUERY_Z   = 2'd2,
    REG_RADIUS_SQ = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MID,
    ST_SQ,
    ST_SUM,
    ST_READ,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic [FLAGS_W-1:0]        flags;
    logic [DIST_W-1:0]         dist_sq;
  } entry_t;

  typedef struct packed {
    logic ins_en;
    logic rd_en;
  } cell_ctrl_t;

endpackage

// ===== sv/ncep_dist.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint distance pipeline
// Three register stages: midpoint and distance magnitude, squares, sum and
// radius test.
// ----------------------------------------------------------------------------
module ncep_dist (
  input  logic                           clk,
  input  logic signed [ncep_pkg::COORD_W-1:0] query_x,
  input  logic signed [ncep_pkg::COORD_W-1:0] query_y,
  input  logic signed [ncep_pkg::COORD_W-1:0] query_z,
  input  logic [ncep_pkg::DIST_W-1:0]         radius_sq,
  input  logic signed [ncep_pkg::COORD_W-1:0] end0_x,
  input  logic signed [ncep_pkg::COORD_W-1:0] end0_y,
  input  logic signed [ncep_pkg::COORD_W-1:0] end0_z,
  input  logic signed [ncep_pkg::COORD_W-1:0] end1_x,
  input  logic signed [ncep_pkg::COORD_W-1:0] end1_y,
  input  logic signed [ncep_pkg::COORD_W-1:0] end1_z,
  output logic signed [ncep_pkg::COORD_W-1:0] mid_x,
  output logic signed [ncep_pkg::COORD_W-1:0] mid_y,
  output logic signed [ncep_pkg::COORD_W-1:0] mid_z,
  output logic [ncep_pkg::DIST_W-1:0]         dist_sq,
  output logic                                in_radius
);
  import ncep_pkg::*;

  localparam int SUM_W = COORD_W + 1;
  localparam int MAG_W = COORD_W;
  localparam int SQ_W = 2 * MAG_W;
  localparam int TOT_W = SQ_W + 2;

  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
  logic signed [COORD_W-1:0] m_x, m_y, m_z;
  logic signed [SUM_W-1:0] d_x, d_y, d_z;
  logic [SUM_W-1:0] a_x, a_y, a_z;
  logic [MAG_W-1:0] mag_x, mag_y, mag_z;
  logic [SQ_W-1:0] sq_x, sq_y, sq_z;
  logic signed [COORD_W-1:0] mid1_x, mid1_y, mid1_z;
  logic signed [COORD_W-1:0] mid2_x, mid2_y, mid2_z;
  logic [TOT_W-1:0] total;

  always_comb begin
    sum_x = SUM_W'(end0_x) + SUM_W'(end1_x);
    sum_y = SUM_W'(end0_y) + SUM_W'(end1_y);
    sum_z = SUM_W'(end0_z) + SUM_W'(end1_z);
    m_x = sum_x[SUM_W-1:1];
    m_y = sum_y[SUM_W-1:1];
    m_z = sum_z[SUM_W-1:1];
    d_x = SUM_W'(m_x) - SUM_W'(query_x);
    d_y = SUM_W'(m_y) - SUM_W'(query_y);
    d_z = SUM_W'(m_z) - SUM_W'(query_z);
    a_x = d_x[SUM_W-1] ? SUM_W'(-d_x) : SUM_W'(d_x);
    a_y = d_y[SUM_W-1] ? SUM_W'(-d_y) : SUM_W'(d_y);
    a_z = d_z[SUM_W-1] ? SUM_W'(-d_z) : SUM_W'(d_z);
    total = TOT_W'(sq_x) + TOT_W'(sq_y) + TOT_W'(sq_z);
  end

  always_ff @(posedge clk) begin
    mag_x <= a_x[MAG_W-1:0];
    mag_y <= a_y[MAG_W-1:0];
    mag_z <= a_z[MAG_W-1:0];
    mid1_x <= m_x;
    mid1_y <= m_y;
    mid1_z <= m_z;
    sq_x <= mag_x * mag_x;
    sq_y <= mag_y * mag_y;
    sq_z <= mag_z * mag_z;
    mid2_x <= mid1_x;
    mid2_y <= mid1_y;
    mid2_z <= mid1_z;
    dist_sq <= total[DIST_W-1:0];
    in_radius <= (total[TOT_W-1:DIST_W] == '0) && (total[DIST_W-1:0] <= radius_sq);
    mid_x <= mid2_x;
    mid_y <= mid2_y;
    mid_z <= mid2_z;
  end

endmodule

// ===== sv/ncep_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pool cell
// Holds one sorted entry, shifts right on insertion and forwards the read bus.
// ----------------------------------------------------------------------------
module ncep_cell #(
  parameter int POOL_DEPTH = ncep_pkg::POOL_DEPTH_DEF,
  parameter int CELL_IDX = 0,
  localparam int CNT_W = $clog2(POOL_DEPTH + 1),
  localparam int CMP_W = (CNT_W > ncep_pkg::READ_IDX_W) ? CNT_W : ncep_pkg::READ_IDX_W
) (
  input  logic                                 clk,
  input  ncep_pkg::cell_ctrl_t                 ctrl,
  input  logic [CNT_W-1:0]                     count,
  input  logic [ncep_pkg::READ_IDX_W-1:0]      read_index,
  input  ncep_pkg::entry_t                     new_entry,
  input  ncep_pkg::entry_t                     left_entry,
  input  logic                                 left_gt,
  input  ncep_pkg::entry_t                     left_bus,
  output ncep_pkg::entry_t                     entry,
  output logic                                 gt,
  output ncep_pkg::entry_t                     bus
);
  import ncep_pkg::*;

  logic occupied;
  logic at_end;
  logic take_new;
  logic hit;

  always_comb begin
    occupied = CNT_W'(CELL_IDX) < count;
    at_end = count == CNT_W'(CELL_IDX);
    gt = occupied && (entry.dist_sq > new_entry.dist_sq);
    take_new = (gt || at_end) && !left_gt;
    hit = CMP_W'(read_index) == CMP_W'(CELL_IDX);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins_en) begin
      if (left_gt) begin
        entry <= left_entry;
      end else if (take_new) begin
        entry <= new_entry;
      end
    end
    if (ctrl.rd_en) begin
      bus <= hit ? entry : left_bus;
    end
  end

endmodule

// ===== sv/nearest_cover_edge_pool.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest cover edge pool
// Keeps the nearest cover edge midpoints to a query point in a sorted chain
// of cells; offers insert, reads return one entry by position.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  in      | in_valid, in_ready, action ... index  | into the block, one word
//  out     | out_valid, out_ready, entry_valid ... | out of the block, one word
//  cfg     | cfg_valid, cfg_ready, cfg_index/data  | into the block, always ready
//
// An offer's result is loaded after the three distance stages (ST_MID, ST_SQ,
// ST_SUM), then in ST_APPLY, in which every cell compares and shifts at once.
// A read's result waits in ST_READ for the read bus, which steps one cell per
// cycle along the chain; a clear (or an unused action) goes straight to ST_APPLY.
// The next word is taken in the cycle after a result is loaded.
// Reset empties the pool by clearing the count; entries need no clearing.
// A waiting result does not block acceptance of the next word; the block
// holds that next word in its final cycle until the output register frees.
module nearest_cover_edge_pool #(
  parameter int POOL_DEPTH = ncep_pkg::POOL_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ncep_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ncep_pkg::DIST_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            action,
  input  logic signed [ncep_pkg::COORD_W-1:0]   end0_x,
  input  logic signed [ncep_pkg::COORD_W-1:0]   end0_y,
  input  logic signed [ncep_pkg::COORD_W-1:0]   end0_z,
  input  logic signed [ncep_pkg::COORD_W-1:0]   end1_x,
  input  logic signed [ncep_pkg::COORD_W-1:0]   end1_y,
  input  logic signed [ncep_pkg::COORD_W-1:0]   end1_z,
  input  logic [ncep_pkg::BUCKET_W-1:0]         edge_bucket,
  input  logic                                  left_open,
  input  logic                                  right_open,
  input  logic                                  edge_slot,
  input  logic [ncep_pkg::READ_IDX_W-1:0]       read_index,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  entry_valid,
  output logic signed [ncep_pkg::COORD_W-1:0]   point_x,
  output logic signed [ncep_pkg::COORD_W-1:0]   point_y,
  output logic signed [ncep_pkg::COORD_W-1:0]   point_z,
  output logic [ncep_pkg::FLAGS_W-1:0]          cover_flags,
  output logic [ncep_pkg::DIST_W-1:0]           distance_sq,
  output logic [ncep_pkg::COUNT_OUT_W-1:0]      pool_count,
  output logic                                  accepted
);
  import ncep_pkg::*;

  localparam int CNT_W = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W = (CNT_W > READ_IDX_W) ? CNT_W : READ_IDX_W;
  localparam int RCNT_W = $clog2(POOL_DEPTH);

  state_t state, state_next;

  logic signed [COORD_W-1:0] query_x, query_y, query_z;
  logic [DIST_W-1:0] radius_sq;

  logic [1:0] item_action;
  logic signed [COORD_W-1:0] item_e0x, item_e0y, item_e0z;
  logic signed [COORD_W-1:0] item_e1x, item_e1y, item_e1z;
  logic [BUCKET_W-1:0] item_bucket;
  logic item_left, item_right, item_slot;
  logic [READ_IDX_W-1:0] item_ridx;

  logic [CNT_W-1:0] count, count_next;
  logic [RCNT_W-1:0] rd_cnt;

  logic signed [COORD_W-1:0] mid_x, mid_y, mid_z;
  logic [DIST_W-1:0] new_dist;
  logic in_radius;

  logic in_fire, apply_fire, cover_ok, full, ins_en, read_ok;
  logic rd_en;
  cell_ctrl_t ctrl;
  entry_t new_entry;
  entry_t zero_entry;
  entry_t cell_entry [POOL_DEPTH];
  entry_t cell_bus [POOL_DEPTH];
  logic cell_gt [POOL_DEPTH];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
      query_z <= '0;
      radius_sq <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_QUERY_X: query_x <= cfg_data[COORD_W-1:0];
        REG_QUERY_Y: query_y <= cfg_data[COORD_W-1:0];
        REG_QUERY_Z: query_z <= cfg_data[COORD_W-1:0];
        REG_RADIUS_SQ: radius_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_ready = 1'b0;
    apply_fire = 1'b0;
    rd_en = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_READ: rd_en = 1'b1;
      ST_APPLY: apply_fire = !out_valid || out_ready;
      default: ;
    endcase
    in_fire = in_valid && in_ready;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (action)
            ACT_OFFER: state_next = ST_MID;
            ACT_READ: state_next = ST_READ;
            default: state_next = ST_APPLY;
          endcase
        end
      end
      ST_MID: state_next = ST_SQ;
      ST_SQ: state_next = ST_SUM;
      ST_SUM: state_next = ST_APPLY;
      ST_READ: begin
        if (rd_cnt == RCNT_W'(POOL_DEPTH - 1)) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (apply_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_action <= action;
      item_e0x <= end0_x;
      item_e0y <= end0_y;
      item_e0z <= end0_z;
      item_e1x <= end1_x;
      item_e1y <= end1_y;
      item_e1z <= end1_z;
      item_bucket <= edge_bucket;
      item_left <= left_open;
      item_right <= right_open;
      item_slot <= edge_slot;
      item_ridx <= read_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
    end else if (in_fire) begin
      rd_cnt <= '0;
    end else if (ctrl.rd_en) begin
      rd_cnt <= rd_cnt + 1'b1;
    end
  end

  ncep_dist u_dist (
    .clk       (clk),
    .query_x   (query_x),
    .query_y   (query_y),
    .query_z   (query_z),
    .radius_sq (radius_sq),
    .end0_x    (item_e0x),
    .end0_y    (item_e0y),
    .end0_z    (item_e0z),
    .end1_x    (item_e1x),
    .end1_y    (item_e1y),
    .end1_z    (item_e1z),
    .mid_x     (mid_x),
    .mid_y     (mid_y),
    .mid_z     (mid_z),
    .dist_sq   (new_dist),
    .in_radius (in_radius)
  );

  always_comb begin
    cover_ok = (item_bucket >= MIN_COVER_BUCKET) || item_left || item_right;
    full = count == CNT_W'(POOL_DEPTH);
    ins_en = apply_fire && (item_action == ACT_OFFER) && cover_ok && in_radius
             && (!full || cell_gt[POOL_DEPTH-1]);
    ctrl.ins_en = ins_en;
    ctrl.rd_en = rd_en;
    read_ok = CMP_W'(item_ridx) < CMP_W'(count);
    new_entry.px = mid_x;
    new_entry.py = mid_y;
    new_entry.pz = mid_z;
    new_entry.flags = {item_slot, item_right, item_left, item_bucket};
    new_entry.dist_sq = new_dist;
    zero_entry = '0;
    count_next = count;
    if (apply_fire && (item_action == ACT_CLEAR)) begin
      count_next = '0;
    end else if (ins_en && !full) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      ncep_cell #(
        .POOL_DEPTH (POOL_DEPTH),
        .CELL_IDX   (i)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count),
        .read_index (item_ridx),
        .new_entry  (new_entry),
        .left_entry (zero_entry),
        .left_gt    (1'b0),
        .left_bus   (zero_entry),
        .entry      (cell_entry[i]),
        .gt         (cell_gt[i]),
        .bus        (cell_bus[i])
      );
    end else begin : g_next
      ncep_cell #(
        .POOL_DEPTH (POOL_DEPTH),
        .CELL_IDX   (i)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count),
        .read_index (item_ridx),
        .new_entry  (new_entry),
        .left_entry (cell_entry[i-1]),
        .left_gt    (cell_gt[i-1]),
        .left_bus   (cell_bus[i-1]),
        .entry      (cell_entry[i]),
        .gt         (cell_gt[i]),
        .bus        (cell_bus[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      entry_valid <= 1'b0;
      point_x <= '0;
      point_y <= '0;
      point_z <= '0;
      cover_flags <= '0;
      distance_sq <= '0;
      if ((item_action == ACT_READ) && read_ok) begin
        entry_valid <= 1'b1;
        point_x <= cell_bus[POOL_DEPTH-1].px;
        point_y <= cell_bus[POOL_DEPTH-1].py;
        point_z <= cell_bus[POOL_DEPTH-1].pz;
        cover_flags <= cell_bus[POOL_DEPTH-1].flags;
        distance_sq <= cell_bus[POOL_DEPTH-1].dist_sq;
      end
      pool_count <= COUNT_OUT_W'(count_next);
      accepted <= ins_en;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(POOL_DEPTH))
    else $error("pool count above depth");

  a_insert_cause: assert property (@(posedge clk) disable iff (rst)
    ins_en |-> cover_ok && in_radius && (item_action == ACT_OFFER))
    else $error("insertion without a passing offer");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(2)) |-> !(cell_entry[0].dist_sq > cell_entry[1].dist_sq))
    else $error("pool head out of order");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (apply_fire && (item_action == ACT_CLEAR)) |=> (count == '0))
    else $error("clear left entries");

  a_read_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_READ) || (state == ST_APPLY))
    else $error("read scan left early");

endmodule

// ===== tb/nearest_cover_edge_pool_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest cover edge pool testbench
// Drives clear, offer and read words into the pool under several query
// points and radii, predicts every result word with a sorted queue of held
// entries, and checks each result field against that prediction.
// ----------------------------------------------------------------------------
module nearest_cover_edge_pool_test;
  import ncep_pkg::*;

  localparam int DEPTH = POOL_DEPTH_DEF;
  localparam longint COORD_LIMIT = 160000000;
  localparam logic [DIST_W-1:0] RADIUS_MAX = 35'h4_0000_0000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [63:0] wide_t;

  typedef struct {
    logic [1:0] act;
    coord_t e0x, e0y, e0z, e1x, e1y, e1z;
    logic [BUCKET_W-1:0] bucket;
    logic left, right, slot;
    logic [READ_IDX_W-1:0] idx;
  } pool_word_t;

  typedef struct {
    logic hit;
    entry_t e;
    logic [COUNT_OUT_W-1:0] count;
    logic inserted;
  } pool_result_t;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIST_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] action;
  coord_t end0_x, end0_y, end0_z, end1_x, end1_y, end1_z;
  logic [BUCKET_W-1:0] edge_bucket;
  logic left_open;
  logic right_open;
  logic edge_slot;
  logic [READ_IDX_W-1:0] read_index;
  logic out_valid;
  logic out_ready;
  logic entry_valid;
  coord_t point_x, point_y, point_z;
  logic [FLAGS_W-1:0] cover_flags;
  logic [DIST_W-1:0] distance_sq;
  logic [COUNT_OUT_W-1:0] pool_count;
  logic accepted;

  nearest_cover_edge_pool dut (.*);

  coord_t q_x = '0;
  coord_t q_y = '0;
  coord_t q_z = '0;
  logic [DIST_W-1:0] radius = '0;
  entry_t held_entries[$];
  pool_result_t expected_results[$];

  int mismatches = 0;
  int cycle_count = 0;
  int rx_mode = 0;
  bit pace_gaps = 0;
  int burst_left = 0;
  pool_word_t last_offer;
  bit have_last = 0;
  int n_offers = 0;
  int n_inserted = 0;
  int n_full_inserts = 0;
  int n_read_hits = 0;
  int n_clears = 0;
  int n_settings = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nearest_cover_edge_pool test failed");
      $finish;
    end
  end

  function automatic coord_t mid_of(coord_t a, coord_t b);
    longint s;
    s = longint'(a) + longint'(b);
    return coord_t'(s >>> 1);
  endfunction

  function automatic longint axis_sq(coord_t a, coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    return d * d;
  endfunction

  function automatic pool_result_t apply_word(pool_word_t w);
    pool_result_t r;
    entry_t ent;
    longint d;
    int pos;
    r.hit = 1'b0;
    r.e = '0;
    r.inserted = 1'b0;
    case (w.act)
      ACT_CLEAR: begin
        held_entries.delete();
        n_clears++;
      end
      ACT_OFFER: begin
        n_offers++;
        if (w.bucket >= MIN_COVER_BUCKET || w.left || w.right) begin
          ent.px = mid_of(w.e0x, w.e1x);
          ent.py = mid_of(w.e0y, w.e1y);
          ent.pz = mid_of(w.e0z, w.e1z);
          ent.flags = {w.slot, w.right, w.left, w.bucket};
          d = axis_sq(ent.px, q_x) + axis_sq(ent.py, q_y) + axis_sq(ent.pz, q_z);
          ent.dist_sq = d[DIST_W-1:0];
          if (d <= longint'(radius) && !(held_entries.size() >= DEPTH &&
              d >= longint'(held_entries[DEPTH-1].dist_sq))) begin
            if (held_entries.size() >= DEPTH) begin
              void'(held_entries.pop_back());
              n_full_inserts++;
            end
            pos = held_entries.size();
            while (pos > 0 && held_entries[pos-1].dist_sq > ent.dist_sq) pos--;
            held_entries.push_back(ent);
            for (int i = held_entries.size() - 1; i > pos; i--) begin
              held_entries[i] = held_entries[i-1];
            end
            held_entries[pos] = ent;
            r.inserted = 1'b1;
            n_inserted++;
          end
        end
      end
      ACT_READ: begin
        if (w.idx < held_entries.size()) begin
          r.hit = 1'b1;
          r.e = held_entries[w.idx];
          n_read_hits++;
        end
      end
      default: ;
    endcase
    r.count = COUNT_OUT_W'(held_entries.size());
    return r;
  endfunction

  function automatic void check_field(string name, wide_t want, wide_t got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    pool_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word arrived while none was expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("entry_valid", want.hit, entry_valid);
        check_field("point_x", want.e.px, point_x);
        check_field("point_y", want.e.py, point_y);
        check_field("point_z", want.e.pz, point_z);
        check_field("cover_flags", want.e.flags, cover_flags);
        check_field("distance_sq", want.e.dist_sq, distance_sq);
        check_field("pool_count", want.count, pool_count);
        check_field("accepted", want.inserted, accepted);
      end
    end
  end

  initial begin : receiver
    int hold;
    int tick;
    hold = 0;
    tick = 0;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      tick++;
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 99) < 65);
        2: out_ready <= ((tick % 7) < 4);
        default: begin
          if (hold > 0) begin
            hold--;
            out_ready <= 1'b0;
          end else if ($urandom_range(0, 99) < 4) begin
            hold = $urandom_range(5, 40);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  function automatic coord_t rand_coord();
    return coord_t'(longint'($urandom_range(0, 2 * COORD_LIMIT)) - COORD_LIMIT);
  endfunction

  function automatic coord_t near_coord(coord_t c, int spread);
    longint v;
    v = longint'(c) + longint'($urandom_range(0, 2 * spread)) - spread;
    if (v > COORD_LIMIT) v = COORD_LIMIT;
    if (v < -COORD_LIMIT) v = -COORD_LIMIT;
    return coord_t'(v);
  endfunction

  function automatic pool_word_t random_word(logic [1:0] act);
    pool_word_t w;
    w.act = act;
    w.e0x = rand_coord();
    w.e0y = rand_coord();
    w.e0z = rand_coord();
    w.e1x = rand_coord();
    w.e1y = rand_coord();
    w.e1z = rand_coord();
    w.bucket = BUCKET_W'($urandom_range(0, 15));
    w.left = 1'($urandom_range(0, 1));
    w.right = 1'($urandom_range(0, 1));
    w.slot = 1'($urandom_range(0, 1));
    w.idx = READ_IDX_W'($urandom_range(0, 127));
    return w;
  endfunction

  function automatic pool_word_t offer_at(longint x0, longint y0, longint z0, longint x1,
                                          longint y1, longint z1, int bucket, bit left,
                                          bit right, bit slot);
    pool_word_t w;
    w = random_word(ACT_OFFER);
    w.e0x = coord_t'(x0);
    w.e0y = coord_t'(y0);
    w.e0z = coord_t'(z0);
    w.e1x = coord_t'(x1);
    w.e1y = coord_t'(y1);
    w.e1z = coord_t'(z1);
    w.bucket = BUCKET_W'(bucket);
    w.left = left;
    w.right = right;
    w.slot = slot;
    return w;
  endfunction

  function automatic pool_word_t near_offer(int spread, bit cover_ok);
    pool_word_t w;
    w = random_word(ACT_OFFER);
    w.e0x = near_coord(q_x, spread);
    w.e0y = near_coord(q_y, spread);
    w.e0z = near_coord(q_z, spread);
    w.e1x = near_coord(q_x, spread);
    w.e1y = near_coord(q_y, spread);
    w.e1z = near_coord(q_z, spread);
    if (!cover_ok) begin
      w.bucket = BUCKET_W'($urandom_range(0, 1));
      w.left = 1'b0;
      w.right = 1'b0;
    end else if (w.bucket < MIN_COVER_BUCKET && !w.left && !w.right) begin
      w.bucket = BUCKET_W'($urandom_range(2, 15));
    end
    return w;
  endfunction

  function automatic pool_word_t read_word(int idx);
    pool_word_t w;
    w = random_word(ACT_READ);
    w.idx = READ_IDX_W'(idx);
    return w;
  endfunction

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_word(pool_word_t w);
    int gap;
    if (pace_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(1, DEPTH + 4);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    action <= w.act;
    end0_x <= w.e0x;
    end0_y <= w.e0y;
    end0_z <= w.e0z;
    end1_x <= w.e1x;
    end1_y <= w.e1y;
    end1_z <= w.e1z;
    edge_bucket <= w.bucket;
    left_open <= w.left;
    right_open <= w.right;
    edge_slot <= w.slot;
    read_index <= w.idx;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(apply_word(w));
    if (w.act == ACT_OFFER) begin
      last_offer = w;
      have_last = 1'b1;
    end
  endtask

  task automatic write_reg(reg_index_t ri, logic [DIST_W-1:0] data);
    drop_valid();
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (ri)
      REG_QUERY_X: q_x = data[COORD_W-1:0];
      REG_QUERY_Y: q_y = data[COORD_W-1:0];
      REG_QUERY_Z: q_z = data[COORD_W-1:0];
      REG_RADIUS_SQ: radius = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_query(longint x, longint y, longint z, logic [DIST_W-1:0] r);
    write_reg(REG_QUERY_X, DIST_W'(x));
    write_reg(REG_QUERY_Y, DIST_W'(y));
    write_reg(REG_QUERY_Z, DIST_W'(z));
    write_reg(REG_RADIUS_SQ, r);
    n_settings++;
  endtask

  // Reset leaves the query at the origin with a zero radius, so only an exact hit fits.
  task automatic test_reset_state();
    send_word(read_word(0));
    send_word(random_word(ACT_UNUSED));
    send_word(offer_at(0, 0, 0, 0, 0, 0, 2, 0, 0, 0));
    send_word(read_word(0));
    send_word(read_word(1));
    send_word(random_word(ACT_CLEAR));
  endtask

  task automatic test_cover_filter();
    set_query(0, 0, 0, RADIUS_MAX);
    send_word(offer_at(8, 0, 0, 8, 0, 0, 0, 0, 0, 0));
    send_word(offer_at(8, 0, 0, 8, 0, 0, 1, 0, 0, 1));
    send_word(offer_at(16, 0, 0, 16, 0, 0, 1, 1, 0, 0));
    send_word(offer_at(8, 0, 0, 8, 0, 0, 0, 0, 1, 1));
    send_word(offer_at(0, 0, 0, 0, 0, 0, 15, 1, 1, 1));
    send_word(offer_at(4, 0, 0, 4, 0, 0, 2, 0, 0, 0));
    send_word(read_word(0));
    send_word(read_word(3));
    send_word(read_word(4));
  endtask

  // Points on the radius are kept, ties keep arrival order, midpoints round down.
  task automatic test_radius_and_rounding();
    set_query(0, 0, 0, 100);
    send_word(random_word(ACT_CLEAR));
    send_word(offer_at(10, 0, 0, 10, 0, 0, 3, 0, 0, 0));
    send_word(offer_at(10, 1, 0, 10, 1, 0, 3, 0, 0, 0));
    send_word(offer_at(6, 8, 0, 6, 9, 0, 4, 1, 0, 1));
    send_word(offer_at(-3, -1, 1, 0, 0, 0, 5, 0, 1, 0));
    send_word(offer_at(-13, 0, 0, -6, 0, 0, 6, 1, 1, 0));
    send_word(read_word(0));
    send_word(read_word(3));
  endtask

  task automatic test_coordinate_extremes();
    set_query(COORD_LIMIT, COORD_LIMIT, COORD_LIMIT, RADIUS_MAX);
    send_word(offer_at(COORD_LIMIT, COORD_LIMIT, COORD_LIMIT,
                       COORD_LIMIT, COORD_LIMIT, COORD_LIMIT, 7, 0, 0, 1));
    send_word(offer_at(-COORD_LIMIT, -COORD_LIMIT, -COORD_LIMIT,
                       COORD_LIMIT, COORD_LIMIT, COORD_LIMIT, 7, 0, 0, 0));
    set_query(-COORD_LIMIT, -COORD_LIMIT, -COORD_LIMIT, RADIUS_MAX);
    send_word(offer_at(-COORD_LIMIT, -COORD_LIMIT, -COORD_LIMIT,
                       -COORD_LIMIT + 1, -COORD_LIMIT + 1, -COORD_LIMIT + 1, 9, 1, 0, 0));
    send_word(read_word(0));
  endtask

  task automatic test_full_pool();
    entry_t tail;
    int tries;
    rx_mode = 3;
    set_query(0, 0, 0, RADIUS_MAX);
    send_word(random_word(ACT_CLEAR));
    tries = 0;
    while (held_entries.size() < DEPTH && tries < 4 * DEPTH) begin
      send_word(near_offer(100000, 1'b1));
      tries++;
    end
    tail = held_entries[held_entries.size() - 1];
    send_word(offer_at(tail.px, tail.py, tail.pz, tail.px, tail.py, tail.pz, 3, 0, 0, 0));
    send_word(offer_at(0, 0, 0, 0, 0, 0, 2, 1, 1, 1));
    send_word(offer_at(131072, 0, 0, 131072, 0, 0, 4, 0, 1, 0));
    send_word(read_word(DEPTH - 1));
    send_word(read_word(0));
  endtask

  task automatic run_random(int items, int clear_pct);
    pool_word_t w;
    int sent;
    int roll;
    int spread;
    sent = 0;
    spread = int'($sqrt(real'(radius))) + 1;
    while (sent < items) begin
      roll = $urandom_range(0, 99);
      if (roll < clear_pct) begin
        w = random_word(ACT_CLEAR);
      end else if (roll < clear_pct + 2) begin
        w = random_word(ACT_UNUSED);
      end else if (roll < clear_pct + 24) begin
        if (held_entries.size() > 0 && $urandom_range(0, 99) < 80) begin
          w = read_word($urandom_range(0, held_entries.size() - 1));
        end else begin
          w = read_word($urandom_range(0, 127));
        end
      end else if (roll < clear_pct + 30 && have_last) begin
        w = last_offer;
      end else if (roll < clear_pct + 37) begin
        w = random_word(ACT_OFFER);
      end else if (roll < clear_pct + 43) begin
        w = near_offer(spread, 1'b0);
      end else begin
        w = near_offer(spread, 1'b1);
      end
      if ($urandom_range(0, 99) == 0) begin
        drop_valid();
        wait_drained();
      end
      send_word(w);
      if (w.act != ACT_UNUSED) sent++;
    end
  endtask

  task automatic test_random_traffic();
    rx_mode = 1;
    pace_gaps = 1'b1;
    set_query(0, 0, 0, RADIUS_MAX);
    run_random(150, 0);
    rx_mode = 2;
    pace_gaps = 1'b0;
    set_query(COORD_LIMIT, -COORD_LIMIT, COORD_LIMIT, 100000000);
    run_random(150, 2);
    rx_mode = 3;
    pace_gaps = 1'b1;
    set_query(-COORD_LIMIT, COORD_LIMIT, -COORD_LIMIT, 0);
    run_random(150, 2);
    rx_mode = 0;
    set_query(rand_coord(), rand_coord(), rand_coord(),
              DIST_W'({$urandom_range(0, 3), $urandom()}));
    run_random(150, 1);
    rx_mode = 1;
    set_query(rand_coord(), rand_coord(), rand_coord(), RADIUS_MAX);
    run_random(150, 0);
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_QUERY_X;
    cfg_data = '0;
    in_valid = 1'b0;
    action = ACT_CLEAR;
    end0_x = '0;
    end0_y = '0;
    end0_z = '0;
    end1_x = '0;
    end1_y = '0;
    end1_z = '0;
    edge_bucket = '0;
    left_open = 1'b0;
    right_open = 1'b0;
    edge_slot = 1'b0;
    read_index = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rx_mode = 1;
    pace_gaps = 1'b1;
    test_reset_state();
    test_cover_filter();
    test_radius_and_rounding();
    test_coordinate_extremes();
    test_full_pool();
    test_random_traffic();

    drop_valid();
    wait_drained();
    repeat (DEPTH + 10) @(posedge clk);
    $display("Covered %0d offers (%0d inserted, %0d into a full pool), %0d hit reads,",
             n_offers, n_inserted, n_full_inserts, n_read_hits);
    $display("%0d clears across %0d query settings; %0d field mismatches.",
             n_clears, n_settings, mismatches);
    if (mismatches == 0) begin
      $display("nearest_cover_edge_pool test passed");
    end else begin
      $display("nearest_cover_edge_pool test failed");
    end
    $finish;
  end

endmodule
